>>> rtl/core/legendre_polynomial_eval_assert.svh
// Assertion macros used by the Legendre evaluator top module.
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef LEGENDRE_POLYNOMIAL_EVAL_ASSERT_SVH
`define LEGENDRE_POLYNOMIAL_EVAL_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LPE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LPE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/lpe_pkg.sv
// ----------------------------------------------------------------------------
// lpe_pkg
// Shared types and constants of the Legendre polynomial evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package lpe_pkg;

  // Field widths of the item channels.
  localparam int DEGREE_W = 16;
  localparam int ARG_W    = 32;
  localparam int IO_FRAC  = 30;

  // Unit values in the Q2.30 item format.
  localparam logic signed [ARG_W-1:0] ONE_Q30     = 32'sh4000_0000;
  localparam logic signed [ARG_W-1:0] NEG_ONE_Q30 = -32'sh4000_0000;

  // Shared multiplier operand and result widths.
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 48;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Request to the shared multiplier.
  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

endpackage

`default_nettype wire

>>> rtl/core/lpe_in_if.sv
// ----------------------------------------------------------------------------
// lpe_in_if
// Input item channel: polynomial degree and argument with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface lpe_in_if import lpe_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [DEGREE_W-1:0]     degree;
  logic signed [ARG_W-1:0] arg;

  modport source (output valid, degree, arg, input ready);
  modport sink   (input valid, degree, arg, output ready);
endinterface

`default_nettype wire

>>> rtl/core/lpe_out_if.sv
// ----------------------------------------------------------------------------
// lpe_out_if
// Result item channel: polynomial value and domain flag with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface lpe_out_if import lpe_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [ARG_W-1:0] poly_value;
  logic                    domain_error;

  modport source (output valid, poly_value, domain_error, input ready);
  modport sink   (input valid, poly_value, domain_error, output ready);
endinterface

`default_nettype wire

>>> rtl/core/lpe_mul.sv
// ----------------------------------------------------------------------------
// lpe_mul
// Shared unsigned 32 x 48 multiplier built from one 32 x 32 array used in
// two passes (PH_LO, PH_HI) and summed in PH_ACC, which raises done.
// ----------------------------------------------------------------------------
`default_nettype none

module lpe_mul import lpe_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire mul_req_t           req,
  output logic [MUL_P_W-1:0]      prod,
  output logic                    busy,
  output logic                    done
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_LO   = 2'd1;
  localparam logic [1:0] PH_HI   = 2'd2;
  localparam logic [1:0] PH_ACC  = 2'd3;

  logic [1:0]              ph;
  logic [MUL_A_W-1:0]      a_r;
  logic [MUL_B_W-1:0]      b_r;
  logic [2*MUL_A_W-1:0]    pp;
  logic [MUL_P_W-1:0]      acc;
  logic [MUL_A_W-1:0]      b_sel;

  // Low word in the first pass, high bits in the second.
  assign b_sel = (ph == PH_LO) ? b_r[MUL_A_W-1:0]
                               : MUL_A_W'(b_r[MUL_B_W-1:MUL_A_W]);

  always_ff @(posedge clk) begin
    if (rst) begin
      ph   <= PH_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (ph)
        PH_IDLE: begin
          if (req.start) begin
            a_r <= req.a;
            b_r <= req.b;
            ph  <= PH_LO;
          end
        end
        PH_LO: begin
          pp <= a_r * b_sel;
          ph <= PH_HI;
        end
        PH_HI: begin
          pp  <= a_r * b_sel;
          acc <= MUL_P_W'(pp);
          ph  <= PH_ACC;
        end
        PH_ACC: begin
          acc  <= acc + {pp[MUL_P_W-MUL_A_W-1:0], {MUL_A_W{1'b0}}};
          ph   <= PH_IDLE;
          done <= 1'b1;
        end
        default: ph <= PH_IDLE;
      endcase
    end
  end

  assign prod = acc;
  assign busy = (ph != PH_IDLE);

endmodule

`default_nettype wire

>>> rtl/core/lpe_div.sv
// ----------------------------------------------------------------------------
// lpe_div
// Restoring divider, one quotient bit per cycle. Flags a quotient that
// does not fit in QW bits.
// ----------------------------------------------------------------------------
`default_nettype none

module lpe_div #(
  parameter int QW = 32,
  parameter int DW = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DW+QW-1:0] num,
  input  wire logic [DW-1:0]    den,
  output logic [QW-1:0]         quo,
  output logic                  sat,
  output logic                  done
);

  localparam int CW = $clog2(QW + 1);

  logic [CW-1:0] cnt;
  logic [DW-1:0] rem;
  logic [DW-1:0] den_r;
  logic [DW:0]   r2;
  logic [DW:0]   diff;
  logic          ge;

  // Trial subtraction of the divisor from the shifted remainder.
  assign r2   = {rem, quo[QW-1]};
  assign ge   = (r2 >= {1'b0, den_r});
  assign diff = r2 - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem   <= num[DW+QW-1:QW];
        quo   <= num[QW-1:0];
        sat   <= (num[DW+QW-1:QW] >= den);
        den_r <= den;
        cnt   <= CW'(QW);
      end else if (cnt != '0) begin
        rem <= ge ? diff[DW-1:0] : r2[DW-1:0];
        quo <= {quo[QW-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/legendre_polynomial_eval.sv
// Degrees 0 and 1, domain errors and, from degree 4 up, endpoint arguments go
// straight to the result; degrees 2 and 3 take one and two passes through the
// shared multiplier. Degree l >= 4 runs l-1 recurrence steps, each of three
// passes through the shared multiplier and a bit-serial divide.
// One item at a time: the next item is accepted once the result is taken.
// Reset (rst, synchronous) returns the sequencer to idle; no clearing pass.
// ----------------------------------------------------------------------------
// legendre_polynomial_eval
// Legendre polynomial P_l(x) in Q2.30 by closed forms for low degrees and
// the upward three-term recurrence otherwise.
// ----------------------------------------------------------------------------
`default_nettype none

module legendre_polynomial_eval import lpe_pkg::*; #(
  parameter int MAX_DEGREE = 1023,
  parameter int FRAC_BITS  = 30
) (
  input  wire logic  clk,
  input  wire logic  rst,
  lpe_in_if.sink     req,
  lpe_out_if.source  rsp
);

  // Working magnitude, divide numerator and quotient widths.
  localparam int MW  = FRAC_BITS + 1;
  localparam int QW  = FRAC_BITS + 2;
  localparam int NW  = FRAC_BITS + 18;
  localparam int CVW = 49;

  // Shifts between the item format and the working format.
  localparam int UPW    = (FRAC_BITS >= IO_FRAC) ? FRAC_BITS - IO_FRAC : 0;
  localparam int DNW    = (FRAC_BITS <  IO_FRAC) ? IO_FRAC - FRAC_BITS : 0;
  localparam int UP_SH  = (UPW > 0) ? UPW - 1 : 0;
  localparam int DN_SH  = (DNW > 0) ? DNW - 1 : 0;
  localparam logic [CVW-1:0] RND_UP = (UPW > 0) ? (CVW'(1) << UP_SH) : '0;
  localparam logic [CVW-1:0] RND_DN = (DNW > 0) ? (CVW'(1) << DN_SH) : '0;
  localparam logic [MW-1:0]  ONE_W  = {1'b1, {FRAC_BITS{1'b0}}};

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SQ   = 4'd1;
  localparam logic [3:0] S_SQW  = 4'd2;
  localparam logic [3:0] S_P3M  = 4'd3;
  localparam logic [3:0] S_P3W  = 4'd4;
  localparam logic [3:0] S_TM   = 4'd5;
  localparam logic [3:0] S_TW   = 4'd6;
  localparam logic [3:0] S_AM   = 4'd7;
  localparam logic [3:0] S_AW   = 4'd8;
  localparam logic [3:0] S_BM   = 4'd9;
  localparam logic [3:0] S_BW   = 4'd10;
  localparam logic [3:0] S_DIV  = 4'd11;
  localparam logic [3:0] S_DW   = 4'd12;
  localparam logic [3:0] S_OUT  = 4'd13;

  logic [3:0]            state;
  logic [DEGREE_W-1:0]   deg_r;
  logic [DEGREE_W-1:0]   step_l;
  logic                  xneg;
  logic [30:0]           xmag;
  logic [MW-1:0]         p1_mag, p2_mag, t_mag;
  logic                  p1_neg, p2_neg, t_neg;
  logic [31:0]           w_mag;
  logic                  w_neg;
  logic [NW-1:0]         ma_r, m_r;
  logic                  m_neg;
  logic [ARG_W-1:0]      val_r;
  logic                  err_r;

  mul_req_t              mul_req;
  logic [MUL_P_W-1:0]    mul_prod;
  logic                  mul_busy, mul_done;
  logic                  div_start, div_sat, div_done;
  logic [QW-1:0]         div_q;
  logic [NW-1:0]         div_num;

  // Input decode helpers.
  logic [31:0]           arg_abs;
  logic [CVW-1:0]        work_full;
  logic                  dom_bad;

  // Closed form helpers.
  logic [61:0]           sq;
  logic [63:0]           sq3, p2_mag64, p2_rnd;
  logic                  p2_neg_c;
  logic [62:0]           x2_sum;
  logic [33:0]           x5;
  logic [63:0]           p3_rnd;

  // Recurrence helpers.
  logic [MUL_P_W-1:0]    t_full;
  logic [NW-1:0]         mb;
  logic                  na, nb;
  logic                  over;
  logic [MW-1:0]         pl_mag;
  logic                  pl_neg;
  logic [CVW-1:0]        io_full;

  function automatic logic [ARG_W-1:0] with_sign(input logic [30:0] mag, input logic neg);
    logic [ARG_W-1:0] v;
    v = {1'b0, mag};
    return neg ? (~v + 1'b1) : v;
  endfunction

  lpe_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .req  (mul_req),
    .prod (mul_prod),
    .busy (mul_busy),
    .done (mul_done)
  );

  lpe_div #(.QW(QW), .DW(DEGREE_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (step_l),
    .quo   (div_q),
    .sat   (div_sat),
    .done  (div_done)
  );

  // Decode of the arriving item.
  assign arg_abs   = req.arg[ARG_W-1] ? (~req.arg + 1'b1) : req.arg;
  assign work_full = ((CVW'(arg_abs[30:0]) << UPW) + RND_DN) >> DNW;
  assign dom_bad   = (req.degree > DEGREE_W'(MAX_DEGREE)) ||
                     (req.arg < NEG_ONE_Q30) || (req.arg > ONE_Q30);

  // Closed forms: P2 = (3x^2 - 1)/2, P3 = x(5x^2 - 3)/2.
  assign sq        = mul_prod[61:0];
  assign sq3       = 64'(sq) + (64'(sq) << 1);
  assign p2_neg_c  = (sq3 < (64'd1 << 60));
  assign p2_mag64  = p2_neg_c ? ((64'd1 << 60) - sq3) : (sq3 - (64'd1 << 60));
  assign p2_rnd    = p2_mag64 + (64'd1 << 30);
  assign x2_sum    = 63'(sq) + (63'd1 << 29);
  assign x5        = 34'(x2_sum[60:30]) + (34'(x2_sum[60:30]) << 2);
  assign p3_rnd    = mul_prod[63:0] + (64'd1 << 30);

  // Recurrence step arithmetic.
  assign t_full  = mul_prod + (MUL_P_W'(1) << 29);
  assign mb      = mul_prod[NW-1:0];
  assign na      = t_neg;
  assign nb      = !p2_neg;
  assign div_num = m_r + NW'(step_l >> 1);
  assign over    = div_sat || (div_q > QW'(ONE_W));
  assign pl_mag  = over ? ONE_W : div_q[MW-1:0];
  assign pl_neg  = m_neg && (pl_mag != '0);
  assign io_full = ((CVW'(pl_mag) << DNW) + RND_UP) >> UPW;

  assign div_start = (state == S_DIV);

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_req = '0;
    unique case (state)
      S_SQ: begin
        mul_req.start = 1'b1;
        mul_req.a     = MUL_A_W'(xmag);
        mul_req.b     = MUL_B_W'(xmag);
      end
      S_P3M: begin
        mul_req.start = 1'b1;
        mul_req.a     = MUL_A_W'(xmag);
        mul_req.b     = MUL_B_W'(w_mag);
      end
      S_TM: begin
        mul_req.start = 1'b1;
        mul_req.a     = MUL_A_W'(xmag);
        mul_req.b     = MUL_B_W'(p1_mag);
      end
      S_AM: begin
        mul_req.start = 1'b1;
        mul_req.a     = MUL_A_W'({step_l, 1'b0} - 1'b1);
        mul_req.b     = MUL_B_W'(t_mag);
      end
      S_BM: begin
        mul_req.start = 1'b1;
        mul_req.a     = MUL_A_W'(step_l - 1'b1);
        mul_req.b     = MUL_B_W'(p2_mag);
      end
      default: mul_req = '0;
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            deg_r <= req.degree;
            xneg  <= req.arg[ARG_W-1];
            xmag  <= arg_abs[30:0];
            err_r <= 1'b0;
            priority if (dom_bad) begin
              val_r <= '0;
              err_r <= 1'b1;
              state <= S_OUT;
            end else if (req.degree == DEGREE_W'(0)) begin
              val_r <= ONE_Q30;
              state <= S_OUT;
            end else if (req.degree == DEGREE_W'(1)) begin
              val_r <= req.arg;
              state <= S_OUT;
            end else if (req.degree == DEGREE_W'(2) || req.degree == DEGREE_W'(3)) begin
              state <= S_SQ;
            end else if (req.arg == ONE_Q30) begin
              val_r <= ONE_Q30;
              state <= S_OUT;
            end else if (req.arg == NEG_ONE_Q30) begin
              val_r <= req.degree[0] ? NEG_ONE_Q30 : ONE_Q30;
              state <= S_OUT;
            end else begin
              p2_mag <= ONE_W;
              p2_neg <= 1'b0;
              p1_mag <= work_full[MW-1:0];
              p1_neg <= req.arg[ARG_W-1] && (work_full[MW-1:0] != '0);
              step_l <= DEGREE_W'(2);
              state  <= S_TM;
            end
          end
        end
        S_SQ:  state <= S_SQW;
        S_SQW: begin
          if (mul_done) begin
            if (deg_r == DEGREE_W'(2)) begin
              val_r <= with_sign(p2_rnd[61:31], p2_neg_c);
              state <= S_OUT;
            end else begin
              w_neg <= (x5 < (34'd3 << 30));
              w_mag <= (x5 < (34'd3 << 30)) ? 32'((34'd3 << 30) - x5)
                                            : 32'(x5 - (34'd3 << 30));
              state <= S_P3M;
            end
          end
        end
        S_P3M: state <= S_P3W;
        S_P3W: begin
          if (mul_done) begin
            val_r <= with_sign(p3_rnd[61:31], xneg ^ w_neg);
            state <= S_OUT;
          end
        end
        S_TM: state <= S_TW;
        S_TW: begin
          if (mul_done) begin
            t_mag <= t_full[30 +: MW];
            t_neg <= (xneg ^ p1_neg) && (t_full[30 +: MW] != '0);
            state <= S_AM;
          end
        end
        S_AM: state <= S_AW;
        S_AW: begin
          if (mul_done) begin
            ma_r  <= mul_prod[NW-1:0];
            state <= S_BM;
          end
        end
        S_BM: state <= S_BW;
        S_BW: begin
          // Signed sum of (2L-1)*t and -(L-1)*P_{L-2} in sign-magnitude.
          if (mul_done) begin
            priority if (na == nb) begin
              m_r   <= ma_r + mb;
              m_neg <= na;
            end else if (ma_r >= mb) begin
              m_r   <= ma_r - mb;
              m_neg <= na;
            end else begin
              m_r   <= mb - ma_r;
              m_neg <= nb;
            end
            state <= S_DIV;
          end
        end
        S_DIV: state <= S_DW;
        S_DW: begin
          if (div_done) begin
            if (step_l == deg_r) begin
              val_r <= with_sign(io_full[30:0], pl_neg);
              state <= S_OUT;
            end else begin
              p2_mag <= p1_mag;
              p2_neg <= p1_neg;
              p1_mag <= pl_mag;
              p1_neg <= pl_neg;
              step_l <= step_l + 1'b1;
              state  <= S_TM;
            end
          end
        end
        S_OUT: begin
          if (rsp.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign req.ready        = (state == S_IDLE);
  assign rsp.valid        = (state == S_OUT);
  assign rsp.poly_value   = val_r;
  assign rsp.domain_error = err_r;

  `include "legendre_polynomial_eval_assert.svh"

  `LPE_ASSERT_NOW(a_rsp_blocks_req, rsp.valid, !req.ready, "input taken while result pending")
  `LPE_ASSERT_NOW(a_err_zero, rsp.valid && rsp.domain_error, rsp.poly_value == '0, "flagged result not zero")
  `LPE_ASSERT_NOW(a_mul_free, mul_req.start, !mul_busy, "multiplier started while busy")
  `LPE_ASSERT_NOW(a_step_range, state == S_TM, (step_l >= DEGREE_W'(2)) && (step_l <= deg_r), "step index out of range")
  `LPE_ASSERT_NEXT(a_accept_busy, req.valid && req.ready, state != S_IDLE, "sequencer idle after accept")

endmodule

`default_nettype wire

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// Legendre polynomial evaluator testbench
// Drives degree/argument items through the request channel with bursty
// timing, predicts P_l(x) in Q2.30 with its own fixed-point model, and
// checks every result item in order against that prediction.
// ----------------------------------------------------------------------------
module testbench;
  import lpe_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_DEG      = 1023;
  localparam int WORK_FRAC    = 30;
  localparam int IDLE_LIMIT   = 300000;
  localparam int HOLDOFF_LEN  = 400;

  typedef struct {
    logic                    wait_drain;
    logic [DEGREE_W-1:0]     degree;
    logic signed [ARG_W-1:0] arg;
  } poly_req_t;

  typedef struct {
    logic signed [ARG_W-1:0] poly_value;
    logic                    domain_error;
  } poly_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lpe_in_if  req_ch ();
  lpe_out_if rsp_ch ();

  legendre_polynomial_eval #(.MAX_DEGREE(MAX_DEG), .FRAC_BITS(WORK_FRAC)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  poly_req_t pending_q[$];
  poly_res_t expected_q[$];
  int        mismatches = 0;
  int        items_in = 0;
  int        idle_cycles = 0;

  always #5 clk = ~clk;

  // Magnitude, sign restore with saturation, and rounded right shift.
  function automatic logic [63:0] mag64(longint v);
    return (v < 0) ? 64'd0 - 64'(v) : 64'(v);
  endfunction

  function automatic longint with_sign(logic [63:0] m, bit neg);
    if (m > 64'h7FFF_FFFF_FFFF_FFFF) m = 64'h7FFF_FFFF_FFFF_FFFF;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint round_shift(longint v, int s);
    logic [63:0] m;
    m = mag64(v);
    m = (m >> s) + ((m >> (s - 1)) & 64'd1);
    return with_sign(m, v < 0);
  endfunction

  function automatic longint clamp_one(longint v, longint one);
    if (v > one) return one;
    if (v < -one) return -one;
    return v;
  endfunction

  // round(x * p / 2^30), split so the partial products stay in 64 bits.
  function automatic longint mul_round_q30(longint x, longint p);
    logic [63:0] a, b, r;
    a = mag64(x);
    b = mag64(p);
    r = ((a * (b >> 32)) << 2) + ((a * (b & 64'hFFFF_FFFF) + (64'd1 << 29)) >> 30);
    return with_sign(r, (x < 0) != (p < 0));
  endfunction

  // Upward three-term recurrence, rounded and clamped at every step.
  function automatic longint legendre_upward(longint x, int l);
    longint      one, prev2, prev1, t, next;
    logic [63:0] ma, mb, m;
    bit          na, nb, neg;
    one   = longint'(1) << WORK_FRAC;
    prev2 = one;
    prev1 = clamp_one(x, one);
    for (int k = 2; k <= l; k++) begin
      t  = mul_round_q30(x, prev1);
      ma = 64'(2 * k - 1) * mag64(t);
      na = t < 0;
      mb = 64'(k - 1) * mag64(prev2);
      nb = !(prev2 < 0);
      if (na == nb) begin
        m = ma + mb; neg = na;
      end else if (ma >= mb) begin
        m = ma - mb; neg = na;
      end else begin
        m = mb - ma; neg = nb;
      end
      m = (m + 64'(k / 2)) / 64'(k);
      next  = clamp_one(with_sign(m, neg), one);
      prev2 = prev1;
      prev1 = next;
    end
    return prev1;
  endfunction

  function automatic poly_res_t predict_legendre(logic [DEGREE_W-1:0] degree,
                                                 logic signed [ARG_W-1:0] arg);
    poly_res_t res;
    longint    one, x, val, x2;
    one = longint'(1) << IO_FRAC;
    x   = longint'(arg);
    res.domain_error = 1'b0;
    if (degree > MAX_DEG || x < -one || x > one) begin
      res.poly_value   = '0;
      res.domain_error = 1'b1;
      return res;
    end
    case (degree)
      0: val = one;
      1: val = x;
      2: val = round_shift(3 * x * x - (longint'(1) << 60), 31);
      3: begin
        x2  = round_shift(x * x, 30);
        val = round_shift(x * (5 * x2 - 3 * one), 31);
      end
      default: begin
        if (x == one) val = one;
        else if (x == -one) val = degree[0] ? -one : one;
        else val = legendre_upward(x, int'(degree));
      end
    endcase
    res.poly_value = ARG_W'(clamp_one(val, one));
    return res;
  endfunction

  // Request driver: bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    logic      next_valid;
    poly_req_t head;
    if (rst) begin
      req_ch.valid  <= 1'b0;
      req_ch.degree <= '0;
      req_ch.arg    <= '0;
    end else begin
      next_valid = req_ch.valid;
      if (req_ch.valid && req_ch.ready) begin
        expected_q.push_back(predict_legendre(req_ch.degree, req_ch.arg));
        items_in++;
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_q.size() != 0) begin
          head = pending_q[0];
          if (!(head.wait_drain && (expected_q.size() != 0))) begin
            void'(pending_q.pop_front());
            req_ch.degree <= head.degree;
            req_ch.arg    <= head.arg;
            next_valid = 1'b1;
            if (burst_left > 0) begin
              burst_left--;
            end else begin
              burst_left = $urandom_range(0, 8);
              gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
          end
        end
      end
      req_ch.valid <= next_valid;
    end
  end

  // Result monitor and receiver stall pattern, with one long hold-off.
  int  stall_phase = 0;
  int  holdoff_left = 0;
  bit  holdoff_done = 0;
  always @(posedge clk) begin
    poly_res_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result item: poly_value %0d", rsp_ch.poly_value);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          if (rsp_ch.poly_value !== want.poly_value) begin
            $error("poly_value: expected %0d, actual %0d", want.poly_value,
                   rsp_ch.poly_value);
            mismatches++;
          end
          if (rsp_ch.domain_error !== want.domain_error) begin
            $error("domain_error: expected %0d, actual %0d", want.domain_error,
                   rsp_ch.domain_error);
            mismatches++;
          end
        end
      end
      if (!holdoff_done && items_in >= 40) begin
        holdoff_done = 1;
        holdoff_left = HOLDOFF_LEN;
      end
      stall_phase = (stall_phase + 1) % 96;
      if (holdoff_left > 0) begin
        holdoff_left--;
        rsp_ch.ready <= 1'b0;
      end else if (stall_phase < 32) begin
        rsp_ch.ready <= 1'b1;
      end else begin
        rsp_ch.ready <= ($urandom_range(0, 2) != 0);
      end
    end
  end

  // Watchdog on cycles without any accepted item.
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (!rst) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic add_item(int degree, longint arg, bit wait_drain = 0);
    poly_req_t it;
    it.wait_drain = wait_drain;
    it.degree     = DEGREE_W'(degree);
    it.arg        = ARG_W'(arg);
    pending_q.push_back(it);
  endtask

  initial begin
    longint one, x;
    int     deg, big_left;
    one      = longint'(1) << IO_FRAC;
    big_left = 3;

    // Directed part: closed forms, endpoints, domain edges, field extremes.
    add_item(0, 0);
    add_item(1, -one / 3);
    add_item(2, one / 2);
    add_item(3, -one / 5);
    add_item(3, one - 1);
    add_item(4, 0);
    add_item(5, one / 7);
    add_item(4, one);
    add_item(5, -one);
    add_item(6, -one);
    add_item(2, one);
    add_item(3, -one);
    add_item(4, one + 1);
    add_item(4, -one - 1);
    add_item(0, 32'sh7FFF_FFFF);
    add_item(1, -(longint'(1) << 31));
    add_item(MAX_DEG, one / 3);
    add_item(MAX_DEG + 1, 0);
    add_item(65535, one / 2);
    add_item(9, -one + 1);
    add_item(12, 32'sh1234_5678);

    // Random part: mostly low degrees with in-range arguments.
    for (int i = 0; i < 120; i++) begin
      case ($urandom_range(0, 19))
        0: deg = $urandom_range(MAX_DEG + 1, 65535);
        1: begin
          if (big_left > 0) begin
            deg = $urandom_range(200, MAX_DEG);
            big_left--;
          end else begin
            deg = $urandom_range(13, 60);
          end
        end
        2, 3, 4: deg = $urandom_range(13, 60);
        default: deg = $urandom_range(0, 12);
      endcase
      case ($urandom_range(0, 9))
        0: x = longint'(signed'($urandom()));
        1: x = ($urandom_range(0, 1) != 0) ? one : -one;
        default: x = longint'($urandom_range(0, 32'h8000_0000)) - one;
      endcase
      add_item(deg, x, i == 70);
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    wait (pending_q.size() == 0 && !req_ch.valid);
    wait (expected_q.size() == 0);
    repeat (50) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/lpe_pkg.sv
rtl/core/lpe_in_if.sv
rtl/core/lpe_out_if.sv
rtl/core/lpe_mul.sv
rtl/core/lpe_div.sv
rtl/core/legendre_polynomial_eval.sv
verif/testbench.sv
